### sv/point_in_triangle_test_macros.svh
// Assertion helpers for the point in triangle test.
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH

// Same-cycle implication.
`define PITT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PITT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/pitt_pkg.sv
package pitt_pkg;

   // input coordinates per item
   localparam int IN_FIELDS = 12;
   localparam int FLD_P = 0;
   localparam int FLD_A = 3;
   localparam int FLD_B = 6;
   localparam int FLD_C = 9;

   // result format
   localparam int WEIGHT_WIDTH = 32;
   localparam int QUOT_BITS = WEIGHT_WIDTH + 1;
   localparam int OUT_INSIDE_BIT = 0;
   localparam int OUT_DEGEN_BIT = 1;
   localparam int OUT_U_LSB = 2;
   localparam int OUT_V_LSB = OUT_U_LSB + WEIGHT_WIDTH;
   localparam int OUT_BITS = OUT_V_LSB + WEIGHT_WIDTH;
   localparam int RSP_WIDTH = ((OUT_BITS + 7) / 8) * 8;

   // dot product slots
   localparam int NUM_DOTS = 5;
   localparam int D00 = 0;
   localparam int D01 = 1;
   localparam int D02 = 2;
   localparam int D11 = 3;
   localparam int D12 = 4;

   // second-level products: den = m0 - m1, nu = m2 - m3, nv = m4 - m5
   localparam int NUM_MULS = 6;
   localparam int MUL_OPA [NUM_MULS] = '{D00, D01, D11, D01, D00, D01};
   localparam int MUL_OPB [NUM_MULS] = '{D11, D01, D02, D12, D12, D02};

endpackage

### sv/point_in_triangle_test.sv
// Channel  | Direction | Payload
// ---------+-----------+---------------------------------------------------------
// req_     | in        | p_x,p_y,p_z,a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
// rsp_     | out       | inside_res, degenerate, weight_u, weight_v
//
// One transfer accepted per cycle while req_tready is high; one result per transfer, in order.
// The pipe holds nine arithmetic stages, one stage per quotient bit of the
// 33-bit restoring divider for both weights, and one output register.
// Stalls freeze the whole pipe: req_tready is low only while a result waits
// in the output register and rsp_tready is low.
// Synchronous active-high reset clears the valid bits only.
`include "point_in_triangle_test_macros.svh"

module point_in_triangle_test #(
   parameter int COORD_WIDTH      = 16,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
   input  logic [((pitt_pkg::IN_FIELDS * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inside_res, degenerate, weight_u, weight_v from bit 0 up, zero padded
   output logic [pitt_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int F   = WEIGHT_FRAC_BITS;
   localparam int DFW = CW + 1;            // edge vector component
   localparam int PW  = 2 * DFW;           // component product
   localparam int DW  = PW + 2;            // dot product
   localparam int H   = DW / 2;            // low half of a split operand
   localparam int HH  = DW - H + 1;        // signed half operand
   localparam int PPW = 2 * HH;            // partial product
   localparam int MW  = 2 * DW;            // full second-level product
   localparam int NW  = MW + 1;            // den, nu, nv
   localparam int FW  = NW + 1;            // after sign fix
   localparam int QB  = pitt_pkg::QUOT_BITS;
   localparam int WW  = pitt_pkg::WEIGHT_WIDTH;
   localparam int XW  = FW + F + QB + 1;   // divider remainder
   localparam int NM  = pitt_pkg::NUM_MULS;
   localparam int ND  = pitt_pkg::NUM_DOTS;
   localparam int LAST = 9 + QB;           // index of output valid

   // pipe control
   logic            en;
   logic [LAST:0]   vld_ff, vld_in;

   assign en         = !vld_ff[LAST] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAST];
   assign vld_in     = {vld_ff[LAST-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: edge vectors e0 = C - A, e1 = B - A, ep = P - A
   logic signed [CW-1:0]  crd [pitt_pkg::IN_FIELDS];
   logic signed [DFW-1:0] s1_e0_ff [3], s1_e0_in [3];
   logic signed [DFW-1:0] s1_e1_ff [3], s1_e1_in [3];
   logic signed [DFW-1:0] s1_ep_ff [3], s1_ep_in [3];

   always_comb begin
      for (int i = 0; i < pitt_pkg::IN_FIELDS; i++) begin
         crd[i] = req_tdata[i*CW +: CW];
      end
      for (int k = 0; k < 3; k++) begin
         s1_e0_in[k] = DFW'(crd[pitt_pkg::FLD_C + k]) - DFW'(crd[pitt_pkg::FLD_A + k]);
         s1_e1_in[k] = DFW'(crd[pitt_pkg::FLD_B + k]) - DFW'(crd[pitt_pkg::FLD_A + k]);
         s1_ep_in[k] = DFW'(crd[pitt_pkg::FLD_P + k]) - DFW'(crd[pitt_pkg::FLD_A + k]);
      end
   end

   // stage 2: component products
   logic signed [PW-1:0] s2_pr_ff [ND][3], s2_pr_in [ND][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_pr_in[pitt_pkg::D00][k] = s1_e0_ff[k] * s1_e0_ff[k];
         s2_pr_in[pitt_pkg::D01][k] = s1_e0_ff[k] * s1_e1_ff[k];
         s2_pr_in[pitt_pkg::D02][k] = s1_e0_ff[k] * s1_ep_ff[k];
         s2_pr_in[pitt_pkg::D11][k] = s1_e1_ff[k] * s1_e1_ff[k];
         s2_pr_in[pitt_pkg::D12][k] = s1_e1_ff[k] * s1_ep_ff[k];
      end
   end

   // stage 3: dot products
   logic signed [DW-1:0] s3_d_ff [ND], s3_d_in [ND];

   always_comb begin
      for (int j = 0; j < ND; j++) begin
         s3_d_in[j] = DW'(s2_pr_ff[j][0]) + DW'(s2_pr_ff[j][1]) + DW'(s2_pr_ff[j][2]);
      end
   end

   // stage 4: each second-level product split into four half-width partials
   logic signed [HH-1:0]  xl, xh, yl, yh;
   logic signed [PPW-1:0] s4_pp_ff [NM][4], s4_pp_in [NM][4];

   always_comb begin
      xl = '0;
      xh = '0;
      yl = '0;
      yh = '0;
      for (int m = 0; m < NM; m++) begin
         xl = {(HH-H)'(0), s3_d_ff[pitt_pkg::MUL_OPA[m]][H-1:0]};
         xh = {s3_d_ff[pitt_pkg::MUL_OPA[m]][DW-1], s3_d_ff[pitt_pkg::MUL_OPA[m]][DW-1:H]};
         yl = {(HH-H)'(0), s3_d_ff[pitt_pkg::MUL_OPB[m]][H-1:0]};
         yh = {s3_d_ff[pitt_pkg::MUL_OPB[m]][DW-1], s3_d_ff[pitt_pkg::MUL_OPB[m]][DW-1:H]};
         s4_pp_in[m][0] = xl * yl;
         s4_pp_in[m][1] = xl * yh;
         s4_pp_in[m][2] = xh * yl;
         s4_pp_in[m][3] = xh * yh;
      end
   end

   // stage 5: recombine partials
   logic signed [MW-1:0] s5_m_ff [NM], s5_m_in [NM];

   always_comb begin
      for (int m = 0; m < NM; m++) begin
         s5_m_in[m] = MW'(s4_pp_ff[m][0])
                    + ((MW'(s4_pp_ff[m][1]) + MW'(s4_pp_ff[m][2])) <<< H)
                    + (MW'(s4_pp_ff[m][3]) <<< (2 * H));
      end
   end

   // stage 6: den, nu, nv
   logic signed [NW-1:0] s6_den_ff, s6_den_in, s6_nu_ff, s6_nu_in, s6_nv_ff, s6_nv_in;

   assign s6_den_in = NW'(s5_m_ff[0]) - NW'(s5_m_ff[1]);
   assign s6_nu_in  = NW'(s5_m_ff[2]) - NW'(s5_m_ff[3]);
   assign s6_nv_in  = NW'(s5_m_ff[4]) - NW'(s5_m_ff[5]);

   // stage 7: make den non-negative, negating nu and nv with it
   logic signed [FW-1:0] s7_den_ff, s7_den_in, s7_nu_ff, s7_nu_in, s7_nv_ff, s7_nv_in;
   logic                 s7_degen_ff, s7_degen_in;

   always_comb begin
      s7_degen_in = (s6_den_ff == '0);
      if (s6_den_ff[NW-1]) begin
         s7_den_in = -FW'(s6_den_ff);
         s7_nu_in  = -FW'(s6_nu_ff);
         s7_nv_in  = -FW'(s6_nv_ff);
      end else begin
         s7_den_in = FW'(s6_den_ff);
         s7_nu_in  = FW'(s6_nu_ff);
         s7_nv_in  = FW'(s6_nv_ff);
      end
   end

   // stage 8: inside decision on exact numerators, magnitudes for the divider
   logic signed [FW+1:0] s8_sum;
   logic                 s8_inside_ff, s8_inside_in, s8_degen_ff;
   logic [FW-1:0]        s8_den_ff, s8_mag_ff [2], s8_mag_in [2];
   logic                 s8_neg_ff [2], s8_neg_in [2];

   always_comb begin
      s8_sum = (FW+2)'(s7_nu_ff) + (FW+2)'(s7_nv_ff) - (FW+2)'(s7_den_ff);
      s8_inside_in = !s7_degen_ff && !s7_nu_ff[FW-1] && !s7_nv_ff[FW-1] && s8_sum[FW+1];
      s8_neg_in[0] = s7_nu_ff[FW-1];
      s8_neg_in[1] = s7_nv_ff[FW-1];
      s8_mag_in[0] = s7_nu_ff[FW-1] ? FW'(-s7_nu_ff) : FW'(s7_nu_ff);
      s8_mag_in[1] = s7_nv_ff[FW-1] ? FW'(-s7_nv_ff) : FW'(s7_nv_ff);
   end

   // stage 9 and divider: index 0 is stage 9, index i+1 is quotient step i
   logic [XW-1:0] dv_den_ff [QB+1], dv_den_in [QB+1];
   logic [XW-1:0] dv_rem_ff [QB+1][2], dv_rem_in [QB+1][2];
   logic [QB-1:0] dv_q_ff [QB+1][2], dv_q_in [QB+1][2];
   logic          dv_neg_ff [QB+1][2], dv_neg_in [QB+1][2];
   logic          dv_big_ff [QB+1][2], dv_big_in [QB+1][2];
   logic          dv_inside_ff [QB+1], dv_inside_in [QB+1];
   logic          dv_degen_ff [QB+1], dv_degen_in [QB+1];
   logic [XW:0]   trial [QB][2];

   always_comb begin
      dv_den_in[0]    = XW'(s8_den_ff);
      dv_inside_in[0] = s8_inside_ff;
      dv_degen_in[0]  = s8_degen_ff;
      for (int w = 0; w < 2; w++) begin
         dv_rem_in[0][w] = XW'(s8_mag_ff[w]) << F;
         dv_q_in[0][w]   = '0;
         dv_neg_in[0][w] = s8_neg_ff[w];
         // quotient would not fit in QB bits
         dv_big_in[0][w] = (XW'(s8_mag_ff[w]) << F) >= (XW'(s8_den_ff) << QB);
      end
      for (int i = 0; i < QB; i++) begin
         dv_den_in[i+1]    = dv_den_ff[i];
         dv_inside_in[i+1] = dv_inside_ff[i];
         dv_degen_in[i+1]  = dv_degen_ff[i];
         for (int w = 0; w < 2; w++) begin
            trial[i][w] = (XW+1)'(dv_rem_ff[i][w]) - (XW+1)'(dv_den_ff[i] << (QB - 1 - i));
            dv_rem_in[i+1][w] = trial[i][w][XW] ? dv_rem_ff[i][w] : trial[i][w][XW-1:0];
            dv_q_in[i+1][w]   = {dv_q_ff[i][w][QB-2:0], !trial[i][w][XW]};
            dv_neg_in[i+1][w] = dv_neg_ff[i][w];
            dv_big_in[i+1][w] = dv_big_ff[i][w];
         end
      end
   end

   // output: saturate, apply sign, zero on a degenerate triangle
   logic [QB-1:0]        lim [2], qs [2];
   logic [WW-1:0]        out_w_ff [2], out_w_in [2];
   logic                 out_inside_ff, out_degen_ff;

   always_comb begin
      for (int w = 0; w < 2; w++) begin
         lim[w] = dv_neg_ff[QB][w] ? (QB'(1) << (WW - 1)) : ((QB'(1) << (WW - 1)) - QB'(1));
         qs[w]  = (dv_big_ff[QB][w] || dv_q_ff[QB][w] > lim[w]) ? lim[w] : dv_q_ff[QB][w];
         if (dv_degen_ff[QB]) begin
            out_w_in[w] = '0;
         end else if (dv_neg_ff[QB][w]) begin
            out_w_in[w] = -qs[w][WW-1:0];
         end else begin
            out_w_in[w] = qs[w][WW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_e0_ff     <= s1_e0_in;
         s1_e1_ff     <= s1_e1_in;
         s1_ep_ff     <= s1_ep_in;
         s2_pr_ff     <= s2_pr_in;
         s3_d_ff      <= s3_d_in;
         s4_pp_ff     <= s4_pp_in;
         s5_m_ff      <= s5_m_in;
         s6_den_ff    <= s6_den_in;
         s6_nu_ff     <= s6_nu_in;
         s6_nv_ff     <= s6_nv_in;
         s7_den_ff    <= s7_den_in;
         s7_nu_ff     <= s7_nu_in;
         s7_nv_ff     <= s7_nv_in;
         s7_degen_ff  <= s7_degen_in;
         s8_inside_ff <= s8_inside_in;
         s8_degen_ff  <= s7_degen_ff;
         s8_den_ff    <= s7_den_ff;
         s8_mag_ff    <= s8_mag_in;
         s8_neg_ff    <= s8_neg_in;
         dv_den_ff    <= dv_den_in;
         dv_rem_ff    <= dv_rem_in;
         dv_q_ff      <= dv_q_in;
         dv_neg_ff    <= dv_neg_in;
         dv_big_ff    <= dv_big_in;
         dv_inside_ff <= dv_inside_in;
         dv_degen_ff  <= dv_degen_in;
         out_w_ff      <= out_w_in;
         out_inside_ff <= dv_inside_ff[QB];
         out_degen_ff  <= dv_degen_ff[QB];
      end
   end

   assign rsp_tdata = {(pitt_pkg::RSP_WIDTH - pitt_pkg::OUT_BITS)'(0),
                       out_w_ff[1], out_w_ff[0], out_degen_ff, out_inside_ff};

   // checks
   `PITT_ASSERT_NOW(a_degen_zero, clock, reset, rsp_tvalid && out_degen_ff, !out_inside_ff && out_w_ff[0] == '0 && out_w_ff[1] == '0, "degenerate result not cleared")
   `PITT_ASSERT_NOW(a_inside_pos, clock, reset, rsp_tvalid && out_inside_ff, !out_w_ff[0][WW-1] && !out_w_ff[1][WW-1], "inside with negative weight")
   `PITT_ASSERT_NEXT(a_stall_hold, clock, reset, !en, $stable(vld_ff), "pipe moved during stall")

endmodule

### test/point_in_triangle_test_tb.sv
`timescale 1ns / 100ps

module point_in_triangle_test_tb;

   localparam int CW      = 16;
   localparam int FRAC    = 16;
   localparam int REQ_W   = ((pitt_pkg::IN_FIELDS * CW + 7) / 8) * 8;
   localparam int N_RAND  = 1900;
   localparam int N_DIR   = 12;

   typedef logic signed [CW-1:0] coord_type;
   typedef coord_type            tri_pt_type [pitt_pkg::IN_FIELDS];
   typedef logic signed [127:0]  exact_type;

   typedef struct packed {
      logic        inside_res;
      logic        degenerate;
      logic [31:0] weight_u;
      logic [31:0] weight_v;
   } hit_type;

   // one row of the directed stimulus; known is set where the answer is typed in
   typedef struct {
      coord_type c [pitt_pkg::IN_FIELDS];
      bit        known;
      hit_type   hit;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // inside_res, degenerate, weight_u, weight_v from bit 0 up, zero padded
   logic [pitt_pkg::RSP_WIDTH-1:0] rsp_tdata;

   hit_type hits_due [$];
   int      fail_cnt;
   int      idle_pct;   // sender gap chance, percent per cycle
   int      stall_pct;  // receiver stall chance, percent per cycle
   bit      feed_done;

   point_in_triangle_test #(.COORD_WIDTH(CW), .WEIGHT_FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Saturated num * 2^FRAC / den, truncated toward zero; den is positive here.
   function automatic logic [31:0] bary_weight(exact_type num, exact_type den);
      logic          neg;
      logic [127:0]  mag;
      logic [127:0]  q;
      logic [127:0]  lim;
      neg = num < 0;
      mag = (neg ? -num : num) << FRAC;
      q   = mag / den;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? 32'(-q) : q[31:0];
   endfunction

   // Exact barycentric test: edges from A, five dot products, then the 2x2 solve.
   function automatic hit_type locate_point(tri_pt_type c);
      exact_type e0 [3], e1 [3], ep [3];
      exact_type d00, d01, d02, d11, d12, den, nu, nv;
      hit_type   h;
      d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
      for (int k = 0; k < 3; k++) begin
         e0[k] = exact_type'(c[pitt_pkg::FLD_C + k]) - exact_type'(c[pitt_pkg::FLD_A + k]);
         e1[k] = exact_type'(c[pitt_pkg::FLD_B + k]) - exact_type'(c[pitt_pkg::FLD_A + k]);
         ep[k] = exact_type'(c[pitt_pkg::FLD_P + k]) - exact_type'(c[pitt_pkg::FLD_A + k]);
         d00 += e0[k] * e0[k];
         d01 += e0[k] * e1[k];
         d02 += e0[k] * ep[k];
         d11 += e1[k] * e1[k];
         d12 += e1[k] * ep[k];
      end
      den = d00 * d11 - d01 * d01;
      nu  = d11 * d02 - d01 * d12;
      nv  = d00 * d12 - d01 * d02;
      h = '0;
      if (den == 0) begin
         h.degenerate = 1'b1;
         return h;
      end
      // flip signs so the inequalities hold for a negative denominator too
      if (den < 0) begin
         den = -den; nu = -nu; nv = -nv;
      end
      h.inside_res = (nu >= 0) && (nv >= 0) && (nu + nv < den);
      h.weight_u   = bary_weight(nu, den);
      h.weight_v   = bary_weight(nv, den);
      return h;
   endfunction

   // Drive one transfer and hold it until accepted.
   task automatic send_tri(tri_pt_type c);
      logic [REQ_W-1:0] d;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      d = '0;
      for (int k = 0; k < pitt_pkg::IN_FIELDS; k++) d[k*CW +: CW] = c[k];
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic coord_type rnd_coord(int span);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   // Random mix: mostly random triangles with nearby points, half of them flat in z,
   // some noise, some collapsed triangles and some extreme values.
   function automatic void make_tri(output tri_pt_type c);
      int        mode;
      int        span;
      coord_type z;
      mode = $urandom_range(99);
      span = ($urandom_range(3) == 0) ? 16000 : 1200;
      z = rnd_coord(span);
      for (int k = 0; k < pitt_pkg::IN_FIELDS; k++) c[k] = coord_type'($urandom);
      if (mode < 55) begin
         for (int k = 0; k < pitt_pkg::IN_FIELDS; k++) c[k] = rnd_coord(span);
         if ($urandom_range(1)) begin
            // coplanar in z
            c[pitt_pkg::FLD_P + 2] = z; c[pitt_pkg::FLD_A + 2] = z;
            c[pitt_pkg::FLD_B + 2] = z; c[pitt_pkg::FLD_C + 2] = z;
         end
      end else if (mode < 70) begin
         // each axis of C copies A or mirrors A through B: collinear or coincident when all axes agree
         for (int k = 0; k < 3; k++) begin
            c[pitt_pkg::FLD_A + k] = rnd_coord(span / 2);
            c[pitt_pkg::FLD_B + k] = rnd_coord(span / 2);
            c[pitt_pkg::FLD_C + k] = $urandom_range(1) ? c[pitt_pkg::FLD_A + k]
                 : coord_type'(2 * c[pitt_pkg::FLD_B + k] - c[pitt_pkg::FLD_A + k]);
         end
      end else if (mode < 85) begin
         for (int k = 0; k < pitt_pkg::IN_FIELDS; k++) begin
            case ($urandom_range(3))
               0: c[k] = 16'sh7FFF;
               1: c[k] = -16'sh8000;
               2: c[k] = '0;
               default: ;
            endcase
         end
      end
   endfunction

   initial begin
      dir_row_type dir [N_DIR];
      tri_pt_type  c;
      hit_type     exp_hit;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      idle_pct   = 0;
      stall_pct  = 0;
      fail_cnt   = 0;
      feed_done  = 0;
      // P, A, B, C; known rows are collapsed triangles: outside, zero weights
      dir[0]  = '{'{default: 16'sh0000}, 1, '{1'b0, 1'b1, 32'h0, 32'h0}};
      dir[1]  = '{'{default: 16'sh7FFF}, 1, '{1'b0, 1'b1, 32'h0, 32'h0}};
      dir[2]  = '{'{default: -16'sh8000}, 1, '{1'b0, 1'b1, 32'h0, 32'h0}};
      dir[3]  = '{'{16'sh0040, 16'sh0040, 0, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0},
                  0, '0};
      dir[4]  = '{'{16'sh0100, 16'sh0100, 0, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0},
                  0, '0};
      dir[5]  = '{'{0, 0, 0, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100, 0}, 0, '0};
      dir[6]  = '{'{16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, '0};
      dir[7]  = '{'{-16'sh8000, -16'sh8000, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, '0};
      dir[8]  = '{'{0, 0, 0, -16'sh8000, -16'sh8000, -16'sh8000,
                    16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh7FFF},
                  0, '0};
      dir[9]  = '{'{16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, -16'sh8000},
                  0, '0};
      // B on A: collapsed
      dir[10] = '{'{5, 6, 7, 16'sh0100, 16'sh0200, 16'sh0300,
                    16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 16'sh0500, 16'sh0600},
                  1, '{1'b0, 1'b1, 32'h0, 32'h0}};
      dir[11] = '{'{-16'sh0080, 16'sh0010, 16'sh0010, 0, 0, 0,
                    16'sh0100, 0, 0, 0, 16'sh0100, 0}, 0, '0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIR; i++) begin
         c = dir[i].c;
         exp_hit = locate_point(c);
         hits_due.push_back(dir[i].known ? dir[i].hit : exp_hit);
         send_tri(c);
      end
      for (int i = 0; i < N_RAND; i++) begin
         case (i * 4 / N_RAND)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         make_tri(c);
         hits_due.push_back(locate_point(c));
         send_tri(c);
      end
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_cnt == 0 && hits_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      hit_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.inside_res = rsp_tdata[pitt_pkg::OUT_INSIDE_BIT];
            got.degenerate = rsp_tdata[pitt_pkg::OUT_DEGEN_BIT];
            got.weight_u   = rsp_tdata[pitt_pkg::OUT_U_LSB +: pitt_pkg::WEIGHT_WIDTH];
            got.weight_v   = rsp_tdata[pitt_pkg::OUT_V_LSB +: pitt_pkg::WEIGHT_WIDTH];
            if (hits_due.size() == 0) begin
               $error("result transfer with nothing pending");
               fail_cnt++;
            end else begin
               want = hits_due.pop_front();
               if (got.inside_res !== want.inside_res) begin
                  $error("inside_res exp %0d got %0d", want.inside_res, got.inside_res);
                  fail_cnt++;
               end
               if (got.degenerate !== want.degenerate) begin
                  $error("degenerate exp %0d got %0d", want.degenerate, got.degenerate);
                  fail_cnt++;
               end
               if (got.weight_u !== want.weight_u) begin
                  $error("weight_u exp %h got %h", want.weight_u, got.weight_u);
                  fail_cnt++;
               end
               if (got.weight_v !== want.weight_v) begin
                  $error("weight_v exp %h got %h", want.weight_v, got.weight_v);
                  fail_cnt++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
